// ===== rtl/core/brf_pkg.sv =====
// brf_pkg: shared types, constants and helpers for the byte ring fifo
// used by brf_ctrl, byte_ring_fifo and brf_checker; no dependencies
`default_nettype none

package brf_pkg;

  localparam int MaxDepth = 1024;
  localparam int MaxRun   = 64;
  localparam int MinSize  = 2;

  localparam int AddrW = $clog2(MaxDepth);
  localparam int SizeW = AddrW + 1;
  localparam int DataW = 8;
  localparam int CntW  = 7;
  localparam int ReqW  = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_WRITE = 2'd0,
    REQ_READ  = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_FLUSH = 2'd3
  } req_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  // result waiting on the ram read data
  typedef struct packed {
    logic             valid;
    logic             ok;
    logic             last;
    logic             mem;
    logic [AddrW-1:0] fill;
    logic [AddrW-1:0] free;
  } res_t;

  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v < SizeW'(MinSize)) r = SizeW'(MinSize);
    if (v > SizeW'(MaxDepth)) r = SizeW'(MaxDepth);
    return r;
  endfunction

  function automatic logic [AddrW-1:0] free_lvl(input logic [SizeW-1:0] eff,
                                                input logic [AddrW-1:0] fill);
    logic [SizeW-1:0] r;
    r = eff - SizeW'(1) - {1'b0, fill};
    return r[AddrW-1:0];
  endfunction

  function automatic logic [AddrW-1:0] next_ptr(input logic [AddrW-1:0] p,
                                                input logic [SizeW-1:0] eff);
    logic [SizeW-1:0] s;
    s = {1'b0, p} + SizeW'(1);
    return (s >= eff) ? '0 : s[AddrW-1:0];
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/brf_ram.sv =====
// brf_ram: generic simple dual port ram, one write and one registered read port
// no package dependency
`default_nettype none

module brf_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/brf_ctrl.sv =====
// brf_ctrl: pointers, fill count, request sequencer and ram access control
// depends on brf_pkg; drives brf_ram and the result stage in byte_ring_fifo
`default_nettype none

module brf_ctrl
  import brf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ReqW-1:0]  req_type_i,
  input  wire logic [CntW-1:0]  read_count_i,
  input  wire logic             cfg_we_i,
  input  wire logic [SizeW-1:0] cfg_wdata_i,
  input  wire logic             out_ready_i,
  output res_t                  pend_o,
  output logic                  ram_we_o,
  output logic [AddrW-1:0]      ram_waddr_o,
  output logic                  ram_re_o,
  output logic [AddrW-1:0]      ram_raddr_o
);

  state_e           state_q, state_d;
  logic [SizeW-1:0] eff_q, eff_d;
  logic [AddrW-1:0] rp_q, rp_d, wp_q, wp_d;
  logic [AddrW-1:0] fill_q, fill_d;
  logic [CntW-1:0]  rem_q, rem_d;
  res_t             pend_q, pend_d;

  logic             p_free, in_ready, acc, run_go;
  logic             full, empty;
  logic [CntW-1:0]  cnt, n;
  logic [AddrW-1:0] fill_dec;
  req_e             req;

  assign req      = req_e'(req_type_i);
  assign p_free   = !pend_q.valid || out_ready_i;
  assign full     = {1'b0, fill_q} == (eff_q - SizeW'(1));
  assign empty    = fill_q == '0;
  assign fill_dec = fill_q - AddrW'(1);

  always_comb begin
    cnt = read_count_i;
    if (cnt == '0) cnt = CntW'(1);
    if (cnt > CntW'(MaxRun)) cnt = CntW'(MaxRun);
    n = (fill_q < AddrW'(cnt)) ? CntW'(fill_q) : cnt;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && req == REQ_READ && !empty && n != CntW'(1)) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (run_go && rem_q == CntW'(1)) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready = 1'b0;
    run_go   = 1'b0;
    case (state_q)
      ST_IDLE: in_ready = p_free;
      ST_RUN:  run_go   = p_free;
      default: ;
    endcase
    in_stall_o = !in_ready;
    acc        = in_valid_i && in_ready;
  end

  always_comb begin
    eff_d       = eff_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    ram_waddr_o = wp_q;
    ram_raddr_o = rp_q;
    if (out_ready_i) pend_d.valid = 1'b0;

    if (cfg_we_i) begin
      eff_d  = clamp_size(cfg_wdata_i);
      rp_d   = '0;
      wp_d   = '0;
      fill_d = '0;
    end else if (acc) begin
      pend_d.valid = 1'b1;
      pend_d.ok    = 1'b0;
      pend_d.last  = 1'b1;
      pend_d.mem   = 1'b0;
      pend_d.fill  = fill_q;
      pend_d.free  = free_lvl(eff_q, fill_q);
      case (req)
        REQ_WRITE: begin
          if (!full) begin
            ram_we_o    = 1'b1;
            wp_d        = next_ptr(wp_q, eff_q);
            fill_d      = fill_q + AddrW'(1);
            pend_d.ok   = 1'b1;
            pend_d.fill = fill_d;
            pend_d.free = free_lvl(eff_q, fill_d);
          end
        end
        REQ_READ: begin
          if (!empty) begin
            ram_re_o    = 1'b1;
            rp_d        = next_ptr(rp_q, eff_q);
            fill_d      = fill_dec;
            rem_d       = n - CntW'(1);
            pend_d.ok   = 1'b1;
            pend_d.mem  = 1'b1;
            pend_d.last = n == CntW'(1);
            pend_d.fill = fill_dec;
            pend_d.free = free_lvl(eff_q, fill_dec);
          end
        end
        REQ_PEEK: begin
          if (!empty) begin
            ram_re_o   = 1'b1;
            pend_d.ok  = 1'b1;
            pend_d.mem = 1'b1;
          end
        end
        REQ_FLUSH: begin
          rp_d        = '0;
          wp_d        = '0;
          fill_d      = '0;
          pend_d.ok   = 1'b1;
          pend_d.fill = '0;
          pend_d.free = free_lvl(eff_q, '0);
        end
        default: ;
      endcase
    end else if (run_go) begin
      ram_re_o     = 1'b1;
      rp_d         = next_ptr(rp_q, eff_q);
      fill_d       = fill_dec;
      rem_d        = rem_q - CntW'(1);
      pend_d.valid = 1'b1;
      pend_d.ok    = 1'b1;
      pend_d.mem   = 1'b1;
      pend_d.last  = rem_q == CntW'(1);
      pend_d.fill  = fill_dec;
      pend_d.free  = free_lvl(eff_q, fill_dec);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      eff_q   <= SizeW'(MaxDepth);
      rp_q    <= '0;
      wp_q    <= '0;
      fill_q  <= '0;
      rem_q   <= '0;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      eff_q   <= eff_d;
      rp_q    <= rp_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      rem_q   <= rem_d;
      pend_q  <= pend_d;
    end
  end

  assign pend_o = pend_q;

endmodule

`default_nettype wire

// ===== rtl/core/byte_ring_fifo.sv =====
// byte_ring_fifo: circular byte fifo with a sizable ring, one slot kept empty
// depends on brf_pkg, brf_ctrl and brf_ram
//
// usage
//   input channel: in_valid_i / in_stall_o carry one request (req_type_i,
//   write_data_i, read_count_i). output channel: out_valid_o / out_stall_i
//   carry one result (read_data_o, ok_o, last_o, fill_level_o, free_level_o).
//   cfg_we_i writes cfg_wdata_i as the ring size (clamped to 2..1024) and
//   empties the fifo; write it only while no request is in flight.
//   result path: the edge that takes a request reads the ram and loads the
//   pending result; the output register then takes it once it is free.
//   requests: write, peek and flush each give one result and do not hold the
//   input; a read run of n bytes holds the input until its last byte is read,
//   one byte per cycle through the single ram read port while the output is not stalled.
//   reset: pointers and fill count clear, size returns to 1024, no result
//   is pending; ram contents are left as they are.
//   stall: a stalled result holds in the output register while one more
//   result can be prepared; after that in_stall_o rises until it drains.
`default_nettype none

module byte_ring_fifo
  import brf_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic [ReqW-1:0]  req_type_i,
  input  wire logic [DataW-1:0] write_data_i,
  input  wire logic [CntW-1:0]  read_count_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic      [DataW-1:0] read_data_o,
  output logic                  ok_o,
  output logic                  last_o,
  output logic      [AddrW-1:0] fill_level_o,
  output logic      [AddrW-1:0] free_level_o,
  input  wire logic             cfg_we_i,
  input  wire logic [SizeW-1:0] cfg_wdata_i
);

  res_t             pend;
  logic             out_ready;
  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [DataW-1:0] ram_rdata;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] data_q;
  logic             ok_q, last_q;
  logic [AddrW-1:0] fill_q, free_q;

  assign out_ready = !out_valid_q || !out_stall_i;

  brf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .read_count_i (read_count_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_ready_i  (out_ready),
    .pend_o       (pend),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr)
  );

  brf_ram #(
    .Depth (MaxDepth),
    .Width (DataW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (write_data_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready) out_valid_d = pend.valid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && pend.valid) begin
      data_q <= pend.mem ? ram_rdata : '0;
      ok_q   <= pend.ok;
      last_q <= pend.last;
      fill_q <= pend.fill;
      free_q <= pend.free;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_data_o  = data_q;
  assign ok_o         = ok_q;
  assign last_o       = last_q;
  assign fill_level_o = fill_q;
  assign free_level_o = free_q;

endmodule

`default_nettype wire

// ===== rtl/core/brf_checker.sv =====
// brf_checker: port level assertions for byte_ring_fifo, bound to the top level
// depends on brf_pkg and byte_ring_fifo
`default_nettype none

module brf_checker
  import brf_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [DataW-1:0] read_data_o,
  input wire logic             ok_o,
  input wire logic             last_o,
  input wire logic [AddrW-1:0] fill_level_o,
  input wire logic [AddrW-1:0] free_level_o,
  input wire logic             cfg_we_i,
  input wire logic [SizeW-1:0] cfg_wdata_i
);

  logic [SizeW-1:0] size_q;
  logic [SizeW-1:0] level_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(MaxDepth);
    end else if (cfg_we_i) begin
      size_q <= clamp_size(cfg_wdata_i);
    end
  end

  assign level_sum = {1'b0, fill_level_o} + {1'b0, free_level_o};

  a_no_result_in_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  a_refusal_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> last_o && read_data_o == '0)
    else $error("refused request must be a single zero result");

  a_levels_match_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_sum == size_q - SizeW'(1))
    else $error("fill plus free does not match ring size");

  a_flush_empty_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fill_level_o == '0 |-> free_level_o == AddrW'(size_q - SizeW'(1)))
    else $error("empty fifo does not report full free space");

  a_stalled_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o) && $stable(last_o))
    else $error("stalled result changed");

endmodule

bind byte_ring_fifo brf_checker u_brf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .read_data_o  (read_data_o),
  .ok_o         (ok_o),
  .last_o       (last_o),
  .fill_level_o (fill_level_o),
  .free_level_o (free_level_o),
  .cfg_we_i     (cfg_we_i),
  .cfg_wdata_i  (cfg_wdata_i)
);

`default_nettype wire

// ===== bench/byte_ring_fifo_test.sv =====
// byte_ring_fifo_test: self-checking bench for the byte ring fifo, predicts each result
// from its own ring model and checks it under random idles and stalls
// depends on brf_pkg and the byte_ring_fifo rtl
module byte_ring_fifo_test;
  import brf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DataW-1:0] data;
    logic             ok;
    logic             last;
    logic [AddrW-1:0] fill;
    logic [AddrW-1:0] free;
  } fifo_result_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  req_e             req_type = REQ_WRITE;
  logic [DataW-1:0] write_data = '0;
  logic [CntW-1:0]  read_count = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [DataW-1:0] res_data;
  logic             res_ok;
  logic             res_last;
  logic [AddrW-1:0] res_fill;
  logic [AddrW-1:0] res_free;
  logic             cfg_we = 1'b0;
  logic [SizeW-1:0] cfg_wdata = '0;

  // ring model
  logic [DataW-1:0] ring_mem [MaxDepth];
  int               ring_rd = 0;
  int               ring_wr = 0;
  int               ring_size = MaxDepth;

  fifo_result_t     pending_results [$];
  int               error_count = 0;
  bit               no_gaps = 1'b0;
  int               hold_request = 0;
  int               hold_left = 0;

  byte_ring_fifo dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .req_type_i   (req_type),
    .write_data_i (write_data),
    .read_count_i (read_count),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .read_data_o  (res_data),
    .ok_o         (res_ok),
    .last_o       (res_last),
    .fill_level_o (res_fill),
    .free_level_o (res_free),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata)
  );

  always #10ns clk = ~clk;

  function automatic int ring_fill();
    return (ring_wr >= ring_rd) ? ring_wr - ring_rd : ring_size - ring_rd + ring_wr;
  endfunction

  function automatic int ring_advance(input int p);
    return (p + 1 >= ring_size) ? 0 : p + 1;
  endfunction

  task automatic push_result(input logic [DataW-1:0] data, input logic ok_bit,
                             input logic last_bit);
    fifo_result_t r;
    int held;
    held = ring_fill();
    r.data = data;
    r.ok = ok_bit;
    r.last = last_bit;
    r.fill = AddrW'(held);
    r.free = AddrW'(ring_size - 1 - held);
    pending_results.push_back(r);
  endtask

  task automatic predict_request(input req_e kind, input logic [DataW-1:0] wdata,
                                 input logic [CntW-1:0] count);
    int run;
    int n;
    int held;
    int i;
    logic [DataW-1:0] d;
    held = ring_fill();
    case (kind)
      REQ_WRITE: begin
        if (ring_advance(ring_wr) == ring_rd) begin
          push_result('0, 1'b0, 1'b1);
        end else begin
          ring_mem[ring_wr] = wdata;
          ring_wr = ring_advance(ring_wr);
          push_result('0, 1'b1, 1'b1);
        end
      end
      REQ_READ: begin
        run = (count == 0) ? 1 : int'(count);
        if (run > MaxRun) run = MaxRun;
        if (held == 0) begin
          push_result('0, 1'b0, 1'b1);
        end else begin
          n = (run < held) ? run : held;
          for (i = 0; i < n; i++) begin
            d = ring_mem[ring_rd];
            ring_rd = ring_advance(ring_rd);
            push_result(d, 1'b1, i + 1 == n);
          end
        end
      end
      REQ_PEEK: begin
        if (held == 0) push_result('0, 1'b0, 1'b1);
        else push_result(ring_mem[ring_rd], 1'b1, 1'b1);
      end
      default: begin
        ring_rd = 0;
        ring_wr = 0;
        push_result('0, 1'b1, 1'b1);
      end
    endcase
  endtask

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("%s", msg);
  endtask

  // called at a rising edge, returns at the edge that takes the request
  task automatic send_req(input req_e kind, input logic [DataW-1:0] wdata,
                          input logic [CntW-1:0] count);
    int gap;
    bit taken;
    gap = 0;
    while (!no_gaps && $urandom_range(99) < 14) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    write_data <= wdata;
    read_count <= count;
    do begin
      @(negedge clk);
      taken = !in_stall;
      if (taken) predict_request(kind, wdata, count);
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_random_request();
    int pick;
    logic [CntW-1:0] count;
    pick = $urandom_range(99);
    count = ($urandom_range(9) < 7) ? CntW'($urandom_range(1, 4)) : CntW'($urandom_range(127));
    if (pick < 55) send_req(REQ_WRITE, DataW'($urandom_range(255)), count);
    else if (pick < 80) send_req(REQ_READ, DataW'($urandom_range(255)), count);
    else if (pick < 95) send_req(REQ_PEEK, DataW'($urandom_range(255)), count);
    else send_req(REQ_FLUSH, DataW'($urandom_range(255)), count);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_size(input logic [SizeW-1:0] v);
    wait_for_results();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    ring_size = (v < MinSize) ? MinSize : (v > MaxDepth) ? MaxDepth : int'(v);
    ring_rd = 0;
    ring_wr = 0;
  endtask

  task automatic test_basic_requests();
    send_req(REQ_PEEK, 8'h00, 7'd1);
    send_req(REQ_READ, 8'h00, 7'd0);
    send_req(REQ_WRITE, 8'h00, 7'd0);
    send_req(REQ_WRITE, 8'hff, 7'd127);
    send_req(REQ_WRITE, 8'ha5, 7'd1);
    send_req(REQ_WRITE, 8'h5a, 7'd1);
    send_req(REQ_PEEK, 8'h00, 7'd1);
    send_req(REQ_READ, 8'hff, 7'd0);
    send_req(REQ_READ, 8'h00, 7'd127);
    send_req(REQ_WRITE, 8'h3c, 7'd1);
    send_req(REQ_FLUSH, 8'h00, 7'd1);
    send_req(REQ_PEEK, 8'h00, 7'd1);
    send_req(REQ_WRITE, 8'h77, 7'd1);
    wait_for_results();
  endtask

  task automatic test_size_limits();
    // size write empties the ring, zero acts as two
    write_size(11'd0);
    send_req(REQ_PEEK, 8'h00, 7'd1);
    send_req(REQ_WRITE, 8'h11, 7'd1);
    send_req(REQ_WRITE, 8'h22, 7'd1);
    send_req(REQ_PEEK, 8'h00, 7'd1);
    send_req(REQ_READ, 8'h00, 7'd5);
    send_req(REQ_READ, 8'h00, 7'd0);
    write_size(11'd3);
    send_req(REQ_WRITE, 8'h01, 7'd1);
    send_req(REQ_WRITE, 8'h02, 7'd1);
    send_req(REQ_WRITE, 8'h03, 7'd1);
    send_req(REQ_READ, 8'h00, 7'd1);
    send_req(REQ_WRITE, 8'h04, 7'd1);
    send_req(REQ_READ, 8'h00, 7'd127);
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    logic [SizeW-1:0] sizes [7];
    int burst;
    int k;
    sizes = '{11'd2, 11'd3, 11'd9, 11'd33, 11'd2047, SizeW'($urandom_range(4, 24)), 11'd1};
    for (k = 0; k < 7; k++) begin
      write_size(sizes[k]);
      burst = (ring_size <= 34) ? ring_size : 70;
      repeat (burst) send_req(REQ_WRITE, DataW'($urandom_range(255)), CntW'($urandom_range(127)));
      send_req(REQ_READ, DataW'($urandom_range(255)), CntW'($urandom_range(64, 127)));
      repeat (11) send_random_request();
    end
    wait_for_results();
  endtask

  task automatic test_output_backpressure();
    write_size(11'd64);
    hold_request = 150;
    repeat (30) send_req(REQ_WRITE, DataW'($urandom_range(255)), 7'd1);
    send_req(REQ_READ, 8'h00, 7'd127);
    send_req(REQ_PEEK, 8'h00, 7'd1);
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    no_gaps = 1'b1;
    repeat (30) send_random_request();
    wait_for_results();
    no_gaps = 1'b0;
  endtask

  always @(posedge clk) begin : result_stall
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (no_gaps) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 14);
    end
  end

  always @(negedge clk) begin : result_check
    fifo_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("unexpected result: data %h ok %b last %b fill %0d free %0d",
                               res_data, res_ok, res_last, res_fill, res_free));
      end else begin
        want = pending_results.pop_front();
        if (res_data !== want.data || res_ok !== want.ok || res_last !== want.last ||
            res_fill !== want.fill || res_free !== want.free) begin
          report_error({
              $sformatf("mismatch: expected data %h ok %b last %b fill %0d free %0d",
                        want.data, want.ok, want.last, want.fill, want.free),
              $sformatf(", got data %h ok %b last %b fill %0d free %0d",
                        res_data, res_ok, res_last, res_fill, res_free)});
        end
      end
    end
  end

  initial begin : run_limit
    #4ms;
    $display("Verification failed");
    $finish;
  end

  initial begin : main_sequence
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_basic_requests();
    test_size_limits();
    test_random_traffic();
    test_output_backpressure();
    test_back_to_back();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
